// File: sv/slpe_pkg.sv
`default_nettype none

package slpe_pkg;

    // Event codes carried in the low nibble of the input data word
    localparam logic [3:0] EV_SYNC_START = 4'd0;
    localparam logic [3:0] EV_CHARGING   = 4'd1;
    localparam logic [3:0] EV_CHARGED    = 4'd2;
    localparam logic [3:0] EV_LOW_BATT   = 4'd3;
    localparam logic [3:0] EV_CHARGE_OFF = 4'd4;
    localparam logic [3:0] EV_DISK_ON    = 4'd5;
    localparam logic [3:0] EV_KB_CONN    = 4'd6;
    localparam logic [3:0] EV_KB_LOST    = 4'd7;
    localparam logic [3:0] EV_SYNC_OK    = 4'd8;
    localparam logic [3:0] EV_SYNC_FAIL  = 4'd9;
    localparam logic [3:0] EV_SAVED      = 4'd10;
    localparam logic [3:0] EV_DISK_OFF   = 4'd11;

    // Charge status
    localparam logic [1:0] CHG_NONE     = 2'd0;
    localparam logic [1:0] CHG_CHARGING = 2'd1;
    localparam logic [1:0] CHG_CHARGED  = 2'd2;
    localparam logic [1:0] CHG_LOW      = 2'd3;

    // Overlay kinds
    localparam logic [2:0] OVL_NONE      = 3'd0;
    localparam logic [2:0] OVL_KB_CONN   = 3'd1;
    localparam logic [2:0] OVL_KB_LOST   = 3'd2;
    localparam logic [2:0] OVL_SAVED     = 3'd3;
    localparam logic [2:0] OVL_SYNC_OK   = 3'd4;
    localparam logic [2:0] OVL_SYNC_FAIL = 3'd5;

    // Overlay durations in ms
    localparam logic [10:0] DUR_KB_CONN   = 11'd1200;
    localparam logic [10:0] DUR_KB_LOST   = 11'd1500;
    localparam logic [10:0] DUR_SYNC_OK   = 11'd1500;
    localparam logic [10:0] DUR_SYNC_FAIL = 11'd2000;
    localparam logic [10:0] DUR_SAVED     = 11'd700;

    localparam logic [10:0] TICK_MS        = 11'd40;
    localparam logic [7:0]  BRIGHT_DEFAULT = 8'd40;

    // Colour channel indices
    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    // 2000 ms triangle sampled every 40 ms: entry j is floor(51 * j / 5)
    localparam logic [7:0] TRI_LUT [26] = '{
        8'd0,   8'd10,  8'd20,  8'd30,  8'd40,  8'd51,  8'd61,  8'd71,  8'd81,
        8'd91,  8'd102, 8'd112, 8'd122, 8'd132, 8'd142, 8'd153, 8'd163, 8'd173,
        8'd183, 8'd193, 8'd204, 8'd214, 8'd224, 8'd234, 8'd244, 8'd255
    };

    // 700 ms fade sampled every 20 ms: entry w is floor(102 * w / 7)
    localparam logic [7:0] UP_LUT [18] = '{
        8'd0,   8'd14,  8'd29,  8'd43,  8'd58,  8'd72,  8'd87,  8'd102, 8'd116,
        8'd131, 8'd145, 8'd160, 8'd174, 8'd189, 8'd204, 8'd218, 8'd233, 8'd247
    };

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic       apply_event;
        logic       mul_en;
        logic [1:0] mul_chan;
        logic       res_en;
        logic [1:0] res_chan;
        logic       commit;
    } cmd_t;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

// File: sv/slpe_ctrl.sv
`default_nettype none

module slpe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output slpe_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL0 = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.apply_event = accept && s_tuser;
        m_valid_next    = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !s_tuser)
                begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_chan = slpe_pkg::CH_R;
                state_next   = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_chan = slpe_pkg::CH_G;
                cmd.res_en   = 1'b1;
                cmd.res_chan = slpe_pkg::CH_R;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_chan = slpe_pkg::CH_B;
                cmd.res_en   = 1'b1;
                cmd.res_chan = slpe_pkg::CH_G;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_chan = slpe_pkg::CH_B;
                state_next   = ST_HOLD;
            end
            ST_HOLD:
            begin
                // wait for the output register to drain
                if (!m_valid_reg || m_tready)
                begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/slpe_datapath.sv
`default_nettype none

module slpe_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_wdata,
    input  wire logic [3:0]     event_code,
    input  wire slpe_pkg::cmd_t cmd,
    output logic [23:0]         colour
);

    // configuration and status
    logic [7:0]  bright_reg;
    logic        disk_reg;
    logic        sync_reg;
    logic        kb_reg;
    logic [1:0]  charge_reg;
    logic [2:0]  ovl_kind_reg;
    logic [10:0] ovl_left_reg;

    // phase kept as residues: 2000 ms cycle in 40 ms steps, 300 ms blink,
    // hue position (phase / 6) with its remainder
    logic [5:0]  tri_k_reg;
    logic [8:0]  p300_rem_reg;
    logic        p300_tog_reg;
    logic [7:0]  hue_q_reg;
    logic [2:0]  hue_r_reg;

    // overlay elapsed time as residues: 180 ms blink, 700 ms fade in 20 ms units
    logic [7:0]  e180_rem_reg;
    logic        e180_tog_reg;
    logic [5:0]  e700_v_reg;

    logic [15:0] prod_reg;
    logic [7:0]  res_reg [3];
    logic [23:0] out_reg;

    logic        ovl_on;
    logic [7:0]  blink_o;
    logic [7:0]  blink_p;
    logic [5:0]  tri_diff;
    logic [4:0]  tri_idx;
    logic [7:0]  tri_val;
    logic [5:0]  up_diff;
    logic [4:0]  up_idx;
    logic [7:0]  up_val;
    logic [7:0]  hpos;
    logic [7:0]  hoff;
    logic [9:0]  h3;
    logic [7:0]  hlo;
    logic [7:0]  hhi;
    logic [7:0]  wr;
    logic [7:0]  wg;
    logic [7:0]  wb;
    logic [15:0] third_prod;
    logic [7:0]  bb_third;
    logic [7:0]  mul_a [3];
    logic [7:0]  mul_f [3];
    logic [7:0]  direct [3];
    logic [2:0]  use_mul;
    logic [7:0]  op_a;
    logic [7:0]  op_f;
    logic        res_use_mul;
    logic [7:0]  res_direct;
    logic [7:0]  res_val;
    logic [9:0]  p300_sum;
    logic [8:0]  e180_sum;
    logic [6:0]  e700_sum;
    logic [3:0]  hue_r_sum;

    assign ovl_on  = (ovl_kind_reg != slpe_pkg::OVL_NONE)
                     && (ovl_kind_reg <= slpe_pkg::OVL_SYNC_FAIL)
                     && (ovl_left_reg != 11'd0);
    assign blink_o = e180_tog_reg ? bright_reg : 8'd0;
    assign blink_p = p300_tog_reg ? bright_reg : 8'd0;

    assign tri_diff = 6'd50 - tri_k_reg;
    assign tri_idx  = (tri_k_reg < 6'd25) ? tri_k_reg[4:0] : tri_diff[4:0];
    assign tri_val  = slpe_pkg::TRI_LUT[tri_idx];

    assign up_diff = 6'd35 - e700_v_reg;
    assign up_idx  = (e700_v_reg <= 6'd17) ? e700_v_reg[4:0] : up_diff[4:0];
    assign up_val  = slpe_pkg::UP_LUT[up_idx];

    // colour wheel
    always_comb
    begin
        hpos = 8'd255 - hue_q_reg;
        if (hpos < 8'd85)
        begin
            hoff = hpos;
        end
        else if (hpos < 8'd170)
        begin
            hoff = hpos - 8'd85;
        end
        else
        begin
            hoff = hpos - 8'd170;
        end
        h3  = {1'b0, hoff, 1'b0} + {2'b00, hoff};
        hlo = h3[7:0];
        hhi = 8'd255 - hlo;
        if (hpos < 8'd85)
        begin
            wr = hhi; wg = 8'd0; wb = hlo;
        end
        else if (hpos < 8'd170)
        begin
            wr = 8'd0; wg = hlo; wb = hhi;
        end
        else
        begin
            wr = hlo; wg = hhi; wb = 8'd0;
        end
    end

    // bb / 3 as (bb * 171) >> 9, exact over eight bits
    assign third_prod = {8'd0, bright_reg} * 16'd171;
    assign bb_third   = {1'b0, third_prod[15:9]};

    // per-channel operands: either a scaled product or a direct level
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mul_a[c]  = 8'd0;
            mul_f[c]  = 8'd0;
            direct[c] = 8'd0;
        end
        use_mul = 3'b000;
        if (ovl_on)
        begin
            unique case (ovl_kind_reg)
                slpe_pkg::OVL_KB_CONN:
                begin
                    direct[1] = blink_o;
                end
                slpe_pkg::OVL_KB_LOST:
                begin
                    direct[0]  = blink_o;
                    use_mul[1] = 1'b1;
                    mul_a[1]   = blink_o;
                    mul_f[1]   = 8'd160;
                end
                slpe_pkg::OVL_SAVED:
                begin
                    use_mul[1] = 1'b1;
                    mul_a[1]   = bright_reg;
                    mul_f[1]   = up_val;
                end
                slpe_pkg::OVL_SYNC_OK:
                begin
                    direct[1] = bright_reg;
                end
                slpe_pkg::OVL_SYNC_FAIL:
                begin
                    direct[0] = blink_o;
                end
                default:
                begin
                end
            endcase
        end
        else if (disk_reg)
        begin
            use_mul = 3'b110;
            mul_a[1] = bright_reg;
            mul_f[1] = tri_val;
            mul_a[2] = bright_reg;
            mul_f[2] = tri_val;
        end
        else if (sync_reg)
        begin
            use_mul = 3'b111;
            mul_a[0] = wr;
            mul_a[1] = wg;
            mul_a[2] = wb;
            mul_f[0] = bright_reg;
            mul_f[1] = bright_reg;
            mul_f[2] = bright_reg;
        end
        else if (charge_reg == slpe_pkg::CHG_LOW)
        begin
            direct[0] = blink_p;
        end
        else if (charge_reg == slpe_pkg::CHG_CHARGING)
        begin
            use_mul = 3'b011;
            mul_a[0] = bright_reg;
            mul_f[0] = tri_val;
            mul_a[1] = {1'b0, bright_reg[7:1]};
            mul_f[1] = tri_val;
        end
        else if (charge_reg == slpe_pkg::CHG_CHARGED)
        begin
            direct[1] = bright_reg;
        end
        else if (kb_reg)
        begin
            direct[1] = bb_third;
            direct[2] = {2'b00, bright_reg[7:2]};
        end
    end

    always_comb
    begin
        unique case (cmd.mul_chan)
            slpe_pkg::CH_R: begin op_a = mul_a[0]; op_f = mul_f[0]; end
            slpe_pkg::CH_G: begin op_a = mul_a[1]; op_f = mul_f[1]; end
            slpe_pkg::CH_B: begin op_a = mul_a[2]; op_f = mul_f[2]; end
            default:        begin op_a = 8'd0;     op_f = 8'd0;     end
        endcase
        unique case (cmd.res_chan)
            slpe_pkg::CH_R: begin res_use_mul = use_mul[0]; res_direct = direct[0]; end
            slpe_pkg::CH_G: begin res_use_mul = use_mul[1]; res_direct = direct[1]; end
            slpe_pkg::CH_B: begin res_use_mul = use_mul[2]; res_direct = direct[2]; end
            default:        begin res_use_mul = 1'b0;       res_direct = 8'd0;      end
        endcase
        res_val = res_use_mul ? slpe_pkg::div255(prod_reg) : res_direct;
    end

    // shared multiplier and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= {8'd0, op_a} * {8'd0, op_f};
        end
        if (cmd.res_en)
        begin
            unique case (cmd.res_chan)
                slpe_pkg::CH_R: res_reg[0] <= res_val;
                slpe_pkg::CH_G: res_reg[1] <= res_val;
                slpe_pkg::CH_B: res_reg[2] <= res_val;
                default:        res_reg[0] <= res_reg[0];
            endcase
        end
        if (cmd.commit)
        begin
            out_reg <= {res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign colour = out_reg;

    assign p300_sum  = {1'b0, p300_rem_reg} + 10'd40;
    assign e180_sum  = {1'b0, e180_rem_reg} + 9'd40;
    assign e700_sum  = {1'b0, e700_v_reg} + 7'd2;
    assign hue_r_sum = {1'b0, hue_r_reg} + 4'd4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= slpe_pkg::BRIGHT_DEFAULT;
        end
        else if (cfg_we)
        begin
            bright_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_reg     <= 1'b0;
            sync_reg     <= 1'b0;
            kb_reg       <= 1'b0;
            charge_reg   <= slpe_pkg::CHG_NONE;
            ovl_kind_reg <= slpe_pkg::OVL_NONE;
            ovl_left_reg <= 11'd0;
            tri_k_reg    <= 6'd0;
            p300_rem_reg <= 9'd0;
            p300_tog_reg <= 1'b0;
            hue_q_reg    <= 8'd0;
            hue_r_reg    <= 3'd0;
            e180_rem_reg <= 8'd0;
            e180_tog_reg <= 1'b0;
            e700_v_reg   <= 6'd0;
        end
        else if (cmd.apply_event)
        begin
            unique case (event_code)
                slpe_pkg::EV_SYNC_START: sync_reg   <= 1'b1;
                slpe_pkg::EV_CHARGING:   charge_reg <= slpe_pkg::CHG_CHARGING;
                slpe_pkg::EV_CHARGED:    charge_reg <= slpe_pkg::CHG_CHARGED;
                slpe_pkg::EV_LOW_BATT:   charge_reg <= slpe_pkg::CHG_LOW;
                slpe_pkg::EV_CHARGE_OFF: charge_reg <= slpe_pkg::CHG_NONE;
                slpe_pkg::EV_DISK_ON:    disk_reg   <= 1'b1;
                slpe_pkg::EV_DISK_OFF:   disk_reg   <= 1'b0;
                slpe_pkg::EV_KB_CONN:
                begin
                    kb_reg       <= 1'b1;
                    ovl_kind_reg <= slpe_pkg::OVL_KB_CONN;
                    ovl_left_reg <= slpe_pkg::DUR_KB_CONN;
                end
                slpe_pkg::EV_KB_LOST:
                begin
                    kb_reg       <= 1'b0;
                    ovl_kind_reg <= slpe_pkg::OVL_KB_LOST;
                    ovl_left_reg <= slpe_pkg::DUR_KB_LOST;
                end
                slpe_pkg::EV_SYNC_OK:
                begin
                    sync_reg     <= 1'b0;
                    ovl_kind_reg <= slpe_pkg::OVL_SYNC_OK;
                    ovl_left_reg <= slpe_pkg::DUR_SYNC_OK;
                end
                slpe_pkg::EV_SYNC_FAIL:
                begin
                    sync_reg     <= 1'b0;
                    ovl_kind_reg <= slpe_pkg::OVL_SYNC_FAIL;
                    ovl_left_reg <= slpe_pkg::DUR_SYNC_FAIL;
                end
                slpe_pkg::EV_SAVED:
                begin
                    ovl_kind_reg <= slpe_pkg::OVL_SAVED;
                    ovl_left_reg <= slpe_pkg::DUR_SAVED;
                end
                default:
                begin
                end
            endcase
            // restart the elapsed-time residues for any new overlay
            if (event_code >= slpe_pkg::EV_KB_CONN && event_code <= slpe_pkg::EV_SAVED)
            begin
                e180_rem_reg <= 8'd0;
                e180_tog_reg <= 1'b0;
                e700_v_reg   <= 6'd0;
            end
        end
        else if (cmd.commit)
        begin
            // advance phase by one tick
            tri_k_reg <= (tri_k_reg == 6'd49) ? 6'd0 : tri_k_reg + 6'd1;
            if (p300_sum >= 10'd300)
            begin
                p300_rem_reg <= 9'(p300_sum - 10'd300);
                p300_tog_reg <= !p300_tog_reg;
            end
            else
            begin
                p300_rem_reg <= p300_sum[8:0];
            end
            if (hue_r_sum >= 4'd6)
            begin
                hue_r_reg <= 3'(hue_r_sum - 4'd6);
                hue_q_reg <= hue_q_reg + 8'd7;
            end
            else
            begin
                hue_r_reg <= hue_r_sum[2:0];
                hue_q_reg <= hue_q_reg + 8'd6;
            end
            // advance overlay elapsed time
            if (e180_sum >= 9'd180)
            begin
                e180_rem_reg <= 8'(e180_sum - 9'd180);
                e180_tog_reg <= !e180_tog_reg;
            end
            else
            begin
                e180_rem_reg <= e180_sum[7:0];
            end
            e700_v_reg <= (e700_sum >= 7'd35) ? 6'(e700_sum - 7'd35) : e700_sum[5:0];
            // count down the overlay, clamping at zero
            if (ovl_left_reg != 11'd0)
            begin
                if (ovl_left_reg > slpe_pkg::TICK_MS)
                begin
                    ovl_left_reg <= ovl_left_reg - slpe_pkg::TICK_MS;
                end
                else
                begin
                    ovl_left_reg <= 11'd0;
                    ovl_kind_reg <= slpe_pkg::OVL_NONE;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/status_led_pattern_engine.sv
// Status LED colour engine.
// Input stream (s_*): one word per item. s_tuser selects the kind: low is a
// 40 ms time tick, high is a status event whose code sits in s_tdata[3:0].
// Events update the status flags and may start a timed overlay; they give no
// output word and are taken without leaving the idle state.
// Output stream (m_*): one RGB word per tick, red in the lowest byte.
// Brightness is written through cfg_we / cfg_wdata while the block is idle;
// the user must keep to this, as the block does not enforce it. A tick is
// taken from IDLE and steps through MUL0, MUL1, MUL2 and FIN: three passes
// through one shared 8x8 multiplier (one per channel, the divide by 255
// folded into the next pass); HOLD then commits the word to the output
// register, and the next item is taken only from IDLE again. The output
// register holds its word until the receiver takes it; an event is still
// accepted while a word waits, but a finished tick holds in the sequencer
// until the output register is free. Reset clears all status, phase and
// overlay state, brightness returns to 40 and the output stream goes empty.
`default_nettype none

module status_led_pattern_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] event_code, [7:4] zero
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata  // brightness
);

    slpe_pkg::cmd_t cmd;

    // sequencer: handshakes and step commands
    slpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // status, phase residues, shared multiplier and output word
    slpe_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .event_code (s_tdata[3:0]),
        .cmd        (cmd),
        .colour     (m_tdata)
    );

`ifndef SYNTHESIS
    // never overwrite a word the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("output word overwritten");

    // a tick makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> !s_tready)
        else $error("tick accepted without entering the multiply sequence");

    // a word goes out only from a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("output valid without commit");

    // no item is taken while the result is being committed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !s_tready)
        else $error("input accepted during commit");
`endif

endmodule

`default_nettype wire
